// File: design/ece_pkg.sv
// ----------------------------------------------------------------------------
// Edge coefficient encoder package
// Shared types and constants for the edge coefficient encoder.
// ----------------------------------------------------------------------------
package ece_pkg;

    localparam int MaxDim = 64;
    localparam int DimW = 7;
    localparam int QueueDepth = 2;

    typedef enum logic [1:0] {
        ST_REDUCED = 2'd0,
        ST_INSIDE  = 2'd1,
        ST_OUTSIDE = 2'd2,
        ST_REJECT  = 2'd3
    } status_t;

    localparam logic [15:0] OFFSET_INSIDE  = 16'd33024;
    localparam logic [15:0] OFFSET_OUTSIDE = 16'd32256;
    localparam logic [63:0] SIGN_MIN       = 64'h8000_0000_0000_0000;

    typedef struct packed {
        status_t         kind;
        logic [63:0]     origin;
        logic [63:0]     step_x;
        logic [63:0]     step_y;
        logic [DimW-1:0] wm1;
        logic [DimW-1:0] hm1;
        logic            round_half;
    } job_t;

endpackage

// File: design/ece_front.sv
// ----------------------------------------------------------------------------
// Edge coefficient encoder front end
// Accepts an edge, checks the inputs, forms the four corners with overflow
// detection and classifies the edge before handing it to the queue.
// ----------------------------------------------------------------------------
module ece_front (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [63:0]              origin_value,
    input  logic [63:0]              step_x,
    input  logic [63:0]              step_y,
    input  logic [ece_pkg::DimW-1:0] tile_width,
    input  logic [ece_pkg::DimW-1:0] tile_height,
    input  logic                     round_half,
    input  logic                     full,
    output logic                     push,
    output ece_pkg::job_t            job
);

    typedef enum logic [1:0] {F_IDLE, F_MUL, F_ADD, F_PUSH} fstate_t;

    localparam int DIMW_L = ece_pkg::DimW;
    localparam logic [DIMW_L-1:0] MAX_DIM_C = DIMW_L'(ece_pkg::MaxDim);

    fstate_t              state_reg;
    logic [63:0]          row_reg, sx_reg, sy_reg;
    logic [DIMW_L-1:0]    wm1_reg, hm1_reg;
    logic                 half_reg;
    logic                 bad_reg;
    logic [63:0]          dx_reg, dy_reg;
    ece_pkg::job_t        job_reg;

    logic                 in_bad;
    logic [63:0]          mag_x, mag_y;
    logic [70:0]          px, py;
    logic                 ovf_x, ovf_y;
    logic [63:0]          dx_next, dy_next;
    logic [63:0]          ex, ey, exy;
    logic                 ovf_add;
    logic                 ors, ands;
    ece_pkg::status_t     kind_next;

    assign in_bad = (tile_width == '0) || (tile_height == '0) ||
                    (tile_width > MAX_DIM_C) || (tile_height > MAX_DIM_C) ||
                    (step_x == ece_pkg::SIGN_MIN) || (step_y == ece_pkg::SIGN_MIN);

    always_comb
    begin
        mag_x   = sx_reg[63] ? (64'd0 - sx_reg) : sx_reg;
        mag_y   = sy_reg[63] ? (64'd0 - sy_reg) : sy_reg;
        px      = 71'(mag_x) * 71'(wm1_reg);
        py      = 71'(mag_y) * 71'(hm1_reg);
        ovf_x   = sx_reg[63] ? (px > 71'(ece_pkg::SIGN_MIN))
                             : (px > 71'(ece_pkg::SIGN_MIN - 64'd1));
        ovf_y   = sy_reg[63] ? (py > 71'(ece_pkg::SIGN_MIN))
                             : (py > 71'(ece_pkg::SIGN_MIN - 64'd1));
        dx_next = sx_reg[63] ? (64'd0 - px[63:0]) : px[63:0];
        dy_next = sy_reg[63] ? (64'd0 - py[63:0]) : py[63:0];
    end

    always_comb
    begin
        ex  = row_reg + dx_reg;
        ey  = row_reg + dy_reg;
        exy = ex + dy_reg;
        ovf_add = ((row_reg[63] == dx_reg[63]) && (ex[63] != row_reg[63])) ||
                  ((row_reg[63] == dy_reg[63]) && (ey[63] != row_reg[63])) ||
                  ((ex[63] == dy_reg[63]) && (exy[63] != ex[63]));
        ors  = row_reg[63] | ex[63] | ey[63] | exy[63];
        ands = row_reg[63] & ex[63] & ey[63] & exy[63];
        if (bad_reg || ovf_add)
        begin
            kind_next = ece_pkg::ST_REJECT;
        end
        else if (!ors)
        begin
            kind_next = ece_pkg::ST_INSIDE;
        end
        else if (ands)
        begin
            kind_next = ece_pkg::ST_OUTSIDE;
        end
        else
        begin
            kind_next = ece_pkg::ST_REDUCED;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            case (state_reg)
                F_IDLE:
                begin
                    if (start)
                    begin
                        row_reg   <= origin_value;
                        sx_reg    <= step_x;
                        sy_reg    <= step_y;
                        wm1_reg   <= tile_width - DIMW_L'(1);
                        hm1_reg   <= tile_height - DIMW_L'(1);
                        half_reg  <= round_half;
                        bad_reg   <= in_bad;
                        state_reg <= F_MUL;
                    end
                end
                F_MUL:
                begin
                    dx_reg    <= dx_next;
                    dy_reg    <= dy_next;
                    bad_reg   <= bad_reg | ovf_x | ovf_y;
                    state_reg <= F_ADD;
                end
                F_ADD:
                begin
                    job_reg.kind       <= kind_next;
                    job_reg.origin     <= row_reg;
                    job_reg.step_x     <= sx_reg;
                    job_reg.step_y     <= sy_reg;
                    job_reg.wm1        <= wm1_reg;
                    job_reg.hm1        <= hm1_reg;
                    job_reg.round_half <= half_reg;
                    state_reg          <= F_PUSH;
                end
                F_PUSH:
                begin
                    if (!full)
                    begin
                        state_reg <= F_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= F_IDLE;
                end
            endcase
        end
    end

    assign busy = (state_reg != F_IDLE);
    assign push = (state_reg == F_PUSH) && !full;
    assign job  = job_reg;

endmodule

// File: design/ece_queue.sv
// ----------------------------------------------------------------------------
// Edge coefficient encoder job queue
// Short first-in first-out queue between the front end and the back end.
// ----------------------------------------------------------------------------
module ece_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  ece_pkg::job_t push_data,
    output logic          full,
    input  logic          pop,
    output logic          empty,
    output ece_pkg::job_t head
);

    localparam int PtrW = $clog2(ece_pkg::QueueDepth);
    localparam int CntW = $clog2(ece_pkg::QueueDepth + 1);

    ece_pkg::job_t       entry_reg [ece_pkg::QueueDepth];
    logic [PtrW-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [CntW-1:0]     count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                entry_reg[wr_ptr_reg] <= push_data;
                wr_ptr_reg <= (wr_ptr_reg == PtrW'(ece_pkg::QueueDepth - 1)) ?
                              '0 : wr_ptr_reg + PtrW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PtrW'(ece_pkg::QueueDepth - 1)) ?
                              '0 : rd_ptr_reg + PtrW'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CntW'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CntW'(1);
            end
        end
    end

    assign full  = (count_reg == CntW'(ece_pkg::QueueDepth));
    assign empty = (count_reg == '0);
    assign head  = entry_reg[rd_ptr_reg];

endmodule

// File: design/ece_back.sv
// ----------------------------------------------------------------------------
// Edge coefficient encoder back end
// Reduces the steps by their binary gcd, divides in three restoring lanes,
// range-checks the coefficients and corners, and issues the result.
// ----------------------------------------------------------------------------
module ece_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    empty,
    input  ece_pkg::job_t           head,
    output logic                    pop,
    output logic                    done,
    output logic [1:0]              status,
    output logic signed [9:0]       coef_x,
    output logic signed [10:0]      coef_y,
    output logic [15:0]             coef_offset
);

    typedef enum logic [2:0] {B_IDLE, B_GEVEN, B_GLOOP, B_DIV, B_RANGE, B_CORNER} bstate_t;

    bstate_t               state_reg;
    ece_pkg::job_t         job_reg;
    logic [63:0]           u_reg, v_reg, g_reg;
    logic [5:0]            sh_reg;
    logic [63:0]           qx_reg, qy_reg, qr_reg;
    logic [63:0]           rx_reg, ry_reg, rr_reg;
    logic [5:0]            cnt_reg;
    logic signed [9:0]     a_reg;
    logic signed [10:0]    b_reg;
    logic signed [18:0]    d_reg;
    logic                  done_reg;
    logic [1:0]            status_reg;
    logic signed [9:0]     coef_x_reg;
    logic signed [10:0]    coef_y_reg;
    logic [15:0]           coef_offset_reg;

    logic [127:0]          lx, ly, lr;
    logic [63:0]           g_next;
    logic                  a_ok, b_ok, k_ok;
    logic signed [18:0]    k_val;
    logic signed [18:0]    bias;
    logic signed [20:0]    tx, ty, n00, n10, n01, n11;
    logic                  corners_ok;

    function automatic logic [127:0] div_step(input logic [63:0] rem,
                                              input logic [63:0] quo,
                                              input logic [63:0] dvs);
        logic [64:0] trial;
        logic [63:0] rem_out;
        logic        bit_out;
        trial = {rem, quo[63]};
        if (trial >= {1'b0, dvs})
        begin
            rem_out = 64'(trial - {1'b0, dvs});
            bit_out = 1'b1;
        end
        else
        begin
            rem_out = trial[63:0];
            bit_out = 1'b0;
        end
        return {rem_out, quo[62:0], bit_out};
    endfunction

    function automatic logic corner_ok(input logic signed [20:0] n,
                                       input logic signed [18:0] bs);
        return (n >= 21'sd256) && ((n + 21'(bs)) <= 21'sd65279);
    endfunction

    always_comb
    begin
        lx     = div_step(rx_reg, qx_reg, g_reg);
        ly     = div_step(ry_reg, qy_reg, g_reg);
        lr     = div_step(rr_reg, qr_reg, g_reg);
        g_next = (u_reg | v_reg) << sh_reg;
        bias   = job_reg.round_half ? 19'sd128 : 19'sd0;
        a_ok   = job_reg.step_x[63] ? (qx_reg <= 64'd512) : (qx_reg <= 64'd511);
        b_ok   = job_reg.step_y[63] ? (qy_reg <= 64'd1024) : (qy_reg <= 64'd1023);
        if (job_reg.origin[63])
        begin
            k_ok  = (qr_reg < 64'd100000) || ((qr_reg == 64'd100000) && (rr_reg == '0));
            k_val = 19'sd0 - 19'(qr_reg[17:0]) - ((rr_reg != '0) ? 19'sd1 : 19'sd0);
        end
        else
        begin
            k_ok  = (qr_reg <= 64'd100000);
            k_val = 19'(qr_reg[17:0]);
        end
        tx  = 21'(a_reg) * $signed({14'd0, job_reg.wm1});
        ty  = 21'(b_reg) * $signed({14'd0, job_reg.hm1});
        n00 = 21'(d_reg);
        n10 = tx + 21'(d_reg);
        n01 = ty + 21'(d_reg);
        n11 = tx + ty + 21'(d_reg);
        corners_ok = corner_ok(n00, bias) && corner_ok(n10, bias) &&
                     corner_ok(n01, bias) && corner_ok(n11, bias);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                B_IDLE:
                begin
                    if (!empty)
                    begin
                        job_reg <= head;
                        u_reg   <= head.step_x[63] ? (64'd0 - head.step_x) : head.step_x;
                        v_reg   <= head.step_y[63] ? (64'd0 - head.step_y) : head.step_y;
                        sh_reg  <= '0;
                        case (head.kind)
                            ece_pkg::ST_REDUCED:
                            begin
                                state_reg <= B_GEVEN;
                            end
                            ece_pkg::ST_INSIDE:
                            begin
                                done_reg        <= 1'b1;
                                status_reg      <= ece_pkg::ST_INSIDE;
                                coef_x_reg      <= '0;
                                coef_y_reg      <= '0;
                                coef_offset_reg <= ece_pkg::OFFSET_INSIDE;
                            end
                            ece_pkg::ST_OUTSIDE:
                            begin
                                done_reg        <= 1'b1;
                                status_reg      <= ece_pkg::ST_OUTSIDE;
                                coef_x_reg      <= '0;
                                coef_y_reg      <= '0;
                                coef_offset_reg <= ece_pkg::OFFSET_OUTSIDE;
                            end
                            default:
                            begin
                                done_reg        <= 1'b1;
                                status_reg      <= ece_pkg::ST_REJECT;
                                coef_x_reg      <= '0;
                                coef_y_reg      <= '0;
                                coef_offset_reg <= '0;
                            end
                        endcase
                    end
                end
                B_GEVEN, B_GLOOP:
                begin
                    if ((u_reg == '0) || (v_reg == '0))
                    begin
                        if (g_next == '0)
                        begin
                            done_reg        <= 1'b1;
                            status_reg      <= ece_pkg::ST_REJECT;
                            coef_x_reg      <= '0;
                            coef_y_reg      <= '0;
                            coef_offset_reg <= '0;
                            state_reg       <= B_IDLE;
                        end
                        else
                        begin
                            g_reg     <= g_next;
                            qx_reg    <= job_reg.step_x[63] ?
                                         (64'd0 - job_reg.step_x) : job_reg.step_x;
                            qy_reg    <= job_reg.step_y[63] ?
                                         (64'd0 - job_reg.step_y) : job_reg.step_y;
                            qr_reg    <= job_reg.origin[63] ?
                                         (64'd0 - job_reg.origin) : job_reg.origin;
                            rx_reg    <= '0;
                            ry_reg    <= '0;
                            rr_reg    <= '0;
                            cnt_reg   <= '0;
                            state_reg <= B_DIV;
                        end
                    end
                    else if (state_reg == B_GEVEN && !u_reg[0] && !v_reg[0])
                    begin
                        u_reg  <= u_reg >> 1;
                        v_reg  <= v_reg >> 1;
                        sh_reg <= sh_reg + 6'd1;
                    end
                    else if (!u_reg[0])
                    begin
                        u_reg     <= u_reg >> 1;
                        state_reg <= B_GLOOP;
                    end
                    else if (!v_reg[0])
                    begin
                        v_reg     <= v_reg >> 1;
                        state_reg <= B_GLOOP;
                    end
                    else if (u_reg >= v_reg)
                    begin
                        u_reg     <= u_reg - v_reg;
                        state_reg <= B_GLOOP;
                    end
                    else
                    begin
                        v_reg     <= v_reg - u_reg;
                        state_reg <= B_GLOOP;
                    end
                end
                B_DIV:
                begin
                    rx_reg  <= lx[127:64];
                    qx_reg  <= lx[63:0];
                    ry_reg  <= ly[127:64];
                    qy_reg  <= ly[63:0];
                    rr_reg  <= lr[127:64];
                    qr_reg  <= lr[63:0];
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd63)
                    begin
                        state_reg <= B_RANGE;
                    end
                end
                B_RANGE:
                begin
                    if (a_ok && b_ok && k_ok)
                    begin
                        a_reg     <= job_reg.step_x[63] ? (10'sd0 - 10'(qx_reg[9:0]))
                                                        : 10'(qx_reg[9:0]);
                        b_reg     <= job_reg.step_y[63] ? (11'sd0 - 11'(qy_reg[10:0]))
                                                        : 11'(qy_reg[10:0]);
                        d_reg     <= 19'sd32768 + k_val - bias;
                        state_reg <= B_CORNER;
                    end
                    else
                    begin
                        done_reg        <= 1'b1;
                        status_reg      <= ece_pkg::ST_REJECT;
                        coef_x_reg      <= '0;
                        coef_y_reg      <= '0;
                        coef_offset_reg <= '0;
                        state_reg       <= B_IDLE;
                    end
                end
                B_CORNER:
                begin
                    done_reg  <= 1'b1;
                    state_reg <= B_IDLE;
                    if (corners_ok)
                    begin
                        status_reg      <= ece_pkg::ST_REDUCED;
                        coef_x_reg      <= a_reg;
                        coef_y_reg      <= b_reg;
                        coef_offset_reg <= d_reg[15:0];
                    end
                    else
                    begin
                        status_reg      <= ece_pkg::ST_REJECT;
                        coef_x_reg      <= '0;
                        coef_y_reg      <= '0;
                        coef_offset_reg <= '0;
                    end
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

    assign pop         = (state_reg == B_IDLE) && !empty;
    assign done        = done_reg;
    assign status      = status_reg;
    assign coef_x      = coef_x_reg;
    assign coef_y      = coef_y_reg;
    assign coef_offset = coef_offset_reg;

endmodule

// File: design/edge_coeff_encode_unit.sv
// ----------------------------------------------------------------------------
// Edge coefficient encoder
// Encodes one tile edge function into hardware edge coefficients.
// ----------------------------------------------------------------------------
//  Channel   Handshake          Payload
//  input     start / busy       origin_value step_x step_y tile_width
//                               tile_height round_half
//  result    done (one cycle)   status coef_x coef_y coef_offset
//
//  An inside, outside or front-rejected edge is answered from the back end's
//  idle state once it leaves the queue. A reduced edge runs the binary gcd
//  loop, one step per cycle, then the three divider lanes in parallel over
//  all 64 quotient bits, then the range and corner checks. The front end is
//  free again once its job leaves F_PUSH for the queue, while the back end
//  works; busy stays high while a job waits for room in the two-entry queue.
//  Reset clears all control state; the receiver cannot stall results.
module edge_coeff_encode_unit (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [63:0]              origin_value,
    input  logic [63:0]              step_x,
    input  logic [63:0]              step_y,
    input  logic [ece_pkg::DimW-1:0] tile_width,
    input  logic [ece_pkg::DimW-1:0] tile_height,
    input  logic                     round_half,
    output logic                     done,
    output logic [1:0]               status,
    output logic signed [9:0]        coef_x,
    output logic signed [10:0]       coef_y,
    output logic [15:0]              coef_offset
);

    logic          push, full, pop, empty;
    ece_pkg::job_t push_job, head_job;

    ece_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .origin_value (origin_value),
        .step_x       (step_x),
        .step_y       (step_y),
        .tile_width   (tile_width),
        .tile_height  (tile_height),
        .round_half   (round_half),
        .full         (full),
        .push         (push),
        .job          (push_job)
    );

    ece_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_job),
        .full      (full),
        .pop       (pop),
        .empty     (empty),
        .head      (head_job)
    );

    ece_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .empty       (empty),
        .head        (head_job),
        .pop         (pop),
        .done        (done),
        .status      (status),
        .coef_x      (coef_x),
        .coef_y      (coef_y),
        .coef_offset (coef_offset)
    );

endmodule

// File: design/ece_checker.sv
// ----------------------------------------------------------------------------
// Edge coefficient encoder checker
// Port-level assertions for the edge coefficient encoder.
// ----------------------------------------------------------------------------
module ece_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                start,
    input logic                busy,
    input logic                done,
    input logic [1:0]          status,
    input logic signed [9:0]   coef_x,
    input logic signed [10:0]  coef_y,
    input logic [15:0]         coef_offset
);

    a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after an input transfer");

    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && status == ece_pkg::ST_REJECT |->
        coef_x == '0 && coef_y == '0 && coef_offset == '0)
        else $error("rejected result carries nonzero coefficients");

    a_inside: assert property (@(posedge clk) disable iff (!rst_n)
        done && status == ece_pkg::ST_INSIDE |->
        coef_x == '0 && coef_y == '0 && coef_offset == ece_pkg::OFFSET_INSIDE)
        else $error("inside result has wrong coefficients");

    a_outside: assert property (@(posedge clk) disable iff (!rst_n)
        done && status == ece_pkg::ST_OUTSIDE |->
        coef_x == '0 && coef_y == '0 && coef_offset == ece_pkg::OFFSET_OUTSIDE)
        else $error("outside result has wrong coefficients");

    a_reduced_range: assert property (@(posedge clk) disable iff (!rst_n)
        done && status == ece_pkg::ST_REDUCED |->
        coef_offset >= 16'd256 && coef_offset <= 16'd65279)
        else $error("reduced offset out of range");

endmodule

bind edge_coeff_encode_unit ece_checker u_ece_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .done        (done),
    .status      (status),
    .coef_x      (coef_x),
    .coef_y      (coef_y),
    .coef_offset (coef_offset)
);
